// ----- rtl/core/ccns_pkg.sv -----
// shared types and constants for the centre-crop nearest-neighbour address mapper
// no dependencies

package ccns_pkg;

	// port and register widths
	localparam int CFG_W       = 13;
	localparam int COORD_W     = 12;
	localparam int ADDR_W      = 24;
	localparam int REG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SRC_W    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_H    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SRC_STRD = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TGT_W    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TGT_H    = 3'd4;

	// crop window recompute sequencer
	typedef enum logic [2:0] {
		CR_IDLE,
		CR_LOAD,
		CR_CMP,
		CR_DIV,
		CR_FIN
	} crop_state_t;

endpackage

// ----- rtl/core/ccns_div_pipe.sv -----
// two-lane pipelined restoring divider, one quotient bit per stage
// no dependencies; quotient must fit in DW bits (num < den * 2**DW)

module ccns_div_pipe #(
	parameter int DW = 13
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*DW-1:0] num_x,
	input  logic [2*DW-1:0] num_y,
	input  logic [DW-1:0]   den_x,
	input  logic [DW-1:0]   den_y,
	output logic            out_valid,
	output logic [DW-1:0]   quo_x,
	output logic [DW-1:0]   quo_y
);

	logic          v_s  [DW];
	logic [DW-1:0] rx_s [DW];
	logic [DW-1:0] nx_s [DW];
	logic [DW-1:0] ry_s [DW];
	logic [DW-1:0] ny_s [DW];

	genvar k;
	generate
		for (k = 0; k < DW; k++) begin : g_stage
			logic          vp;
			logic [DW-1:0] rpx, npx, rpy, npy;
			logic [DW:0]   tx, ty;
			logic          gex, gey;

			if (k == 0) begin : g_first
				assign vp  = in_valid;
				assign rpx = num_x[2*DW-1:DW];
				assign npx = num_x[DW-1:0];
				assign rpy = num_y[2*DW-1:DW];
				assign npy = num_y[DW-1:0];
			end else begin : g_next
				assign vp  = v_s[k-1];
				assign rpx = rx_s[k-1];
				assign npx = nx_s[k-1];
				assign rpy = ry_s[k-1];
				assign npy = ny_s[k-1];
			end

			assign tx  = {rpx, npx[DW-1]};
			assign ty  = {rpy, npy[DW-1]};
			assign gex = tx >= {1'b0, den_x};
			assign gey = ty >= {1'b0, den_y};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= vp;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rx_s[k] <= gex ? DW'(tx - {1'b0, den_x}) : tx[DW-1:0];
					ry_s[k] <= gey ? DW'(ty - {1'b0, den_y}) : ty[DW-1:0];
					nx_s[k] <= {npx[DW-2:0], gex};
					ny_s[k] <= {npy[DW-2:0], gey};
				end
			end
		end
	endgenerate

	assign out_valid = v_s[DW-1];
	assign quo_x     = nx_s[DW-1];
	assign quo_y     = ny_s[DW-1];

endmodule

// ----- rtl/core/center_crop_nearest_scaler_addr.sv -----
// top level of the centre-crop nearest-neighbour address mapper
// depends on ccns_pkg and ccns_div_pipe
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tdata: out_col, out_row
// m_axis    out  tvalid/tready         tdata: in_col, in_row, in_address; tuser: skip
// cfg       in   cfg_we                cfg_index, cfg_data
//
// one destination pixel per clock while neither the crop recompute nor a full skid register holds
// the input off; column and row are scaled by bit-per-stage pipelined dividers
// after reset and after each register write the crop window is recomputed by a
// shared iterative divider through CR_LOAD, CR_CMP, CR_DIV and CR_FIN when a trim is
// needed, else through CR_LOAD and CR_CMP only, with s_axis_tready low meanwhile
// a stalled output parks one transfer in a skid register; the pipeline holds
// while that register is full

module center_crop_nearest_scaler_addr #(
	parameter int MAX_DIM = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [ccns_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // out_col, out_row
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [ccns_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // in_col, in_row, in_address
	output logic                               m_axis_tuser,  // skip
	input  logic                               cfg_we,
	input  logic [ccns_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [ccns_pkg::CFG_W-1:0]         cfg_data
);

	localparam int CFG_W   = ccns_pkg::CFG_W;
	localparam int COORD_W = ccns_pkg::COORD_W;
	localparam int ADDR_W  = ccns_pkg::ADDR_W;
	localparam int REG_MAX = (1 << CFG_W) - 1;
	localparam int DIM_CAP = (MAX_DIM > REG_MAX) ? REG_MAX : MAX_DIM;
	localparam int DW      = $clog2(DIM_CAP + 1);
	localparam int CW      = (COORD_W > DW) ? COORD_W : DW;
	localparam int CNT_W   = $clog2(DW);

	// configuration registers
	logic [CFG_W-1:0] src_w_q, src_h_q, src_strd_q, tgt_w_q, tgt_h_q;
	logic             cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index inside {[ccns_pkg::REG_SRC_W:ccns_pkg::REG_TGT_H]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q    <= CFG_W'(400);
			src_h_q    <= CFG_W'(400);
			src_strd_q <= CFG_W'(400);
			tgt_w_q    <= CFG_W'(240);
			tgt_h_q    <= CFG_W'(240);
		end else if (cfg_we) begin
			case (cfg_index)
				ccns_pkg::REG_SRC_W:    src_w_q    <= cfg_data;
				ccns_pkg::REG_SRC_H:    src_h_q    <= cfg_data;
				ccns_pkg::REG_SRC_STRD: src_strd_q <= cfg_data;
				ccns_pkg::REG_TGT_W:    tgt_w_q    <= cfg_data;
				ccns_pkg::REG_TGT_H:    tgt_h_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped dimensions
	logic [DW-1:0] sw_e, sh_e, st_e, tw_e, th_e;

	assign sw_e = (src_w_q > CFG_W'(DIM_CAP))    ? DW'(DIM_CAP) : DW'(src_w_q);
	assign sh_e = (src_h_q > CFG_W'(DIM_CAP))    ? DW'(DIM_CAP) : DW'(src_h_q);
	assign st_e = (src_strd_q > CFG_W'(DIM_CAP)) ? DW'(DIM_CAP) : DW'(src_strd_q);
	assign tw_e = (tgt_w_q > CFG_W'(DIM_CAP))    ? DW'(DIM_CAP) : DW'(tgt_w_q);
	assign th_e = (tgt_h_q > CFG_W'(DIM_CAP))    ? DW'(DIM_CAP) : DW'(tgt_h_q);

	// crop window sequencer
	ccns_pkg::crop_state_t state_q, state_nxt;
	logic [2*DW-1:0] a_q, b_q;
	logic [DW-1:0]   rem_q, quo_q, den_q;
	logic [CNT_W-1:0] cnt_q;
	logic            trim_w_q, zero_q, skip_q;
	logic [DW-1:0]   crop_left_q, crop_top_q, crop_cols_q, crop_rows_q;
	logic            busy;
	logic [DW:0]     div_t;
	logic            div_ge;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ccns_pkg::CR_LOAD: state_nxt = ccns_pkg::CR_CMP;
			ccns_pkg::CR_CMP: begin
				if (zero_q || (a_q == b_q)) begin
					state_nxt = ccns_pkg::CR_IDLE;
				end else begin
					state_nxt = ccns_pkg::CR_DIV;
				end
			end
			ccns_pkg::CR_DIV: begin
				if (cnt_q == CNT_W'(DW - 1)) begin
					state_nxt = ccns_pkg::CR_FIN;
				end
			end
			ccns_pkg::CR_FIN:  state_nxt = ccns_pkg::CR_IDLE;
			ccns_pkg::CR_IDLE: state_nxt = ccns_pkg::CR_IDLE;
			default:           state_nxt = ccns_pkg::CR_LOAD;
		endcase
		if (cfg_hit) begin
			state_nxt = ccns_pkg::CR_LOAD;
		end
	end

	always_comb begin
		busy = (state_q != ccns_pkg::CR_IDLE);
	end

	assign div_t  = {rem_q, quo_q[DW-1]};
	assign div_ge = div_t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccns_pkg::CR_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_left_q <= '0;
			crop_top_q  <= '0;
			crop_cols_q <= '0;
			crop_rows_q <= '0;
			zero_q      <= 1'b0;
			skip_q      <= 1'b0;
			trim_w_q    <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ccns_pkg::CR_LOAD: begin
					zero_q <= (sw_e == '0) || (sh_e == '0) || (tw_e == '0) || (th_e == '0);
					skip_q <= st_e < sw_e;
				end
				ccns_pkg::CR_CMP: begin
					crop_left_q <= '0;
					crop_top_q  <= '0;
					crop_cols_q <= sw_e;
					crop_rows_q <= sh_e;
					trim_w_q    <= a_q > b_q;
					cnt_q       <= '0;
				end
				ccns_pkg::CR_DIV: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ccns_pkg::CR_FIN: begin
					if (trim_w_q) begin
						crop_cols_q <= quo_q;
						crop_left_q <= (sw_e - quo_q) >> 1;
					end else begin
						crop_rows_q <= quo_q;
						crop_top_q  <= (sh_e - quo_q) >> 1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ccns_pkg::CR_LOAD: begin
				a_q <= {{DW{1'b0}}, sw_e} * {{DW{1'b0}}, th_e};
				b_q <= {{DW{1'b0}}, sh_e} * {{DW{1'b0}}, tw_e};
			end
			ccns_pkg::CR_CMP: begin
				if (a_q > b_q) begin
					rem_q <= b_q[2*DW-1:DW];
					quo_q <= b_q[DW-1:0];
					den_q <= th_e;
				end else begin
					rem_q <= a_q[2*DW-1:DW];
					quo_q <= a_q[DW-1:0];
					den_q <= tw_e;
				end
			end
			ccns_pkg::CR_DIV: begin
				rem_q <= div_ge ? DW'(div_t - {1'b0, den_q}) : div_t[DW-1:0];
				quo_q <= {quo_q[DW-2:0], div_ge};
			end
			default: ;
		endcase
	end

	// pixel pipeline
	logic             en;
	logic             skid_v_q, out_v_q;
	logic             in_xfer;
	logic [COORD_W-1:0] x_in, y_in;
	logic [DW-1:0]    tw_m1, th_m1, x_sat, y_sat;

	assign en            = !skid_v_q;
	assign s_axis_tready = en && !busy;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	assign x_in  = s_axis_tdata[COORD_W-1:0];
	assign y_in  = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign tw_m1 = tw_e - 1'b1;
	assign th_m1 = th_e - 1'b1;
	assign x_sat = (CW'(x_in) > CW'(tw_m1)) ? tw_m1 : DW'(x_in);
	assign y_sat = (CW'(y_in) > CW'(th_m1)) ? th_m1 : DW'(y_in);

	logic            v_s1, v_s2, v_s3, v_s4, v_s5, v_div;
	logic [DW-1:0]   x_s1, y_s1;
	logic [2*DW-1:0] px_s2, py_s2;
	logic [DW-1:0]   qx, qy;
	logic [DW-1:0]   sx_s3, sy_s3;
	logic [2*DW-1:0] pa_s4;
	logic [DW-1:0]   sx_s4, sy_s4;
	logic [COORD_W-1:0] col_s5, row_s5;
	logic [ADDR_W-1:0]  addr_s5;
	logic            skip_s5;

	ccns_div_pipe #(
		.DW (DW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num_x     (px_s2),
		.num_y     (py_s2),
		.den_x     (tw_e),
		.den_y     (th_e),
		.out_valid (v_div),
		.quo_x     (qx),
		.quo_y     (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_div;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_sat;
			y_s1    <= y_sat;
			px_s2   <= {{DW{1'b0}}, x_s1} * {{DW{1'b0}}, crop_cols_q};
			py_s2   <= {{DW{1'b0}}, y_s1} * {{DW{1'b0}}, crop_rows_q};
			sx_s3   <= crop_left_q + qx;
			sy_s3   <= crop_top_q + qy;
			pa_s4   <= {{DW{1'b0}}, sy_s3} * {{DW{1'b0}}, st_e};
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
			col_s5  <= zero_q ? '0 : COORD_W'(sx_s4);
			row_s5  <= zero_q ? '0 : COORD_W'(sy_s4);
			addr_s5 <= zero_q ? '0 : ADDR_W'({1'b0, pa_s4} + (2*DW+1)'(sx_s4));
			skip_s5 <= zero_q || skip_q;
		end
	end

	// output register and skid
	logic [COORD_W-1:0] out_col_q, out_row_q, skid_col_q, skid_row_q;
	logic [ADDR_W-1:0]  out_addr_q, skid_addr_q;
	logic               out_skip_q, skid_skip_q;
	logic               load_out, load_skid, pop_skid;

	assign load_out  = !skid_v_q && (!out_v_q || m_axis_tready);
	assign load_skid = !skid_v_q && out_v_q && !m_axis_tready && v_s5;
	assign pop_skid  = skid_v_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= v_s5;
			end
			if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (pop_skid) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_col_q  <= col_s5;
			out_row_q  <= row_s5;
			out_addr_q <= addr_s5;
			out_skip_q <= skip_s5;
		end else if (pop_skid) begin
			out_col_q  <= skid_col_q;
			out_row_q  <= skid_row_q;
			out_addr_q <= skid_addr_q;
			out_skip_q <= skid_skip_q;
		end
		if (load_skid) begin
			skid_col_q  <= col_s5;
			skid_row_q  <= row_s5;
			skid_addr_q <= addr_s5;
			skid_skip_q <= skip_s5;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_addr_q, out_row_q, out_col_q};
	assign m_axis_tuser  = out_skip_q;

endmodule

// ----- verif/center_crop_nearest_scaler_addr_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for center_crop_nearest_scaler_addr: a directed table, then
// randomised register phases with pixel streams, results checked against table values or a built-in predictor
// depends on ccns_pkg and center_crop_nearest_scaler_addr

module center_crop_nearest_scaler_addr_test;

	localparam int CFG_W       = ccns_pkg::CFG_W;
	localparam int COORD_W     = ccns_pkg::COORD_W;
	localparam int ADDR_W      = ccns_pkg::ADDR_W;
	localparam int REG_IDX_W   = ccns_pkg::REG_IDX_W;
	localparam int IN_TDATA_W  = ccns_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = ccns_pkg::OUT_TDATA_W;
	localparam logic [REG_IDX_W-1:0] REG_SRC_W    = ccns_pkg::REG_SRC_W;
	localparam logic [REG_IDX_W-1:0] REG_SRC_H    = ccns_pkg::REG_SRC_H;
	localparam logic [REG_IDX_W-1:0] REG_SRC_STRD = ccns_pkg::REG_SRC_STRD;
	localparam logic [REG_IDX_W-1:0] REG_TGT_W    = ccns_pkg::REG_TGT_W;
	localparam logic [REG_IDX_W-1:0] REG_TGT_H    = ccns_pkg::REG_TGT_H;

	localparam int MAX_DIM     = 4096;
	localparam int REG_COUNT   = int'(REG_TGT_H) + 1;
	localparam int IDLE_PCT    = 14;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASES      = 24;
	localparam int DIR_ROWS    = 35;
	localparam int CFG_TOP     = (1 << CFG_W) - 1;
	localparam int COORD_TOP   = (1 << COORD_W) - 1;
	localparam logic [REG_IDX_W-1:0] REG_NONE = REG_TGT_H + 3'd1;

	typedef struct {
		logic [COORD_W-1:0] in_col;
		logic [COORD_W-1:0] in_row;
		logic [ADDR_W-1:0]  in_address;
		logic               skip;
	} src_pixel_t;

	typedef enum logic {DO_PIXEL, DO_WRITE} step_kind_t;

	typedef struct {
		step_kind_t           kind;
		logic [REG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     value;
		logic [COORD_W-1:0]   col;
		logic [COORD_W-1:0]   row;
		logic                 fixed;
		src_pixel_t           want;
	} table_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // out_col, out_row
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // in_col, in_row, in_address
	logic                   m_axis_tuser;        // skip
	logic                   cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_index = REG_SRC_W;
	logic [CFG_W-1:0]       cfg_data = '0;

	logic [CFG_W-1:0] reg_file [REG_COUNT];
	longint unsigned  win_left, win_top, win_cols, win_rows;
	bit               win_empty;
	src_pixel_t       pending_q [$];
	int               mismatches = 0;
	int               idle_cycles = 0;
	bit               steady = 1'b0;

	table_row_t dir_table [DIR_ROWS] = '{
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd0, 12'd0, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd239, 12'd239, 1'b1,
			'{12'd398, 12'd398, 24'd159598, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd4095, 12'd4095, 1'b1,
			'{12'd398, 12'd398, 24'd159598, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd0, 12'd239, 1'b1,
			'{12'd0, 12'd398, 24'd159200, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd120, 12'd37, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_TGT_W, 13'd0, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd4095, 12'd0, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b1}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd0, 12'd4095, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b1}},
		'{DO_WRITE, REG_TGT_W, 13'd320, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd319, 12'd239, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd0, 12'd0, 1'b1, '{12'd0, 12'd50, 24'd20000, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd4095, 12'd4095, 1'b0,
			'{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_SRC_STRD, 13'd100, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd319, 12'd239, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd160, 12'd120, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_SRC_W, 13'h1FFF, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_SRC_H, 13'd4096, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_SRC_STRD, 13'd4096, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_TGT_W, 13'd4096, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_TGT_H, 13'd4096, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd4095, 12'd4095, 1'b1,
			'{12'd4095, 12'd4095, 24'd16777215, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd2048, 12'd1, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_NONE, 13'd0, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd4095, 12'd4095, 1'b1,
			'{12'd4095, 12'd4095, 24'd16777215, 1'b0}},
		'{DO_WRITE, REG_SRC_H, 13'd0, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd17, 12'd9, 1'b1, '{12'd0, 12'd0, 24'd0, 1'b1}},
		'{DO_WRITE, REG_SRC_H, 13'd1, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_TGT_H, 13'd1, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_TGT_W, 13'd1, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd4095, 12'd4095, 1'b0,
			'{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_SRC_W, 13'd1, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_WRITE, REG_TGT_W, 13'd4096, 12'd0, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd100, 12'd0, 1'b0, '{12'd0, 12'd0, 24'd0, 1'b0}},
		'{DO_PIXEL, REG_SRC_W, 13'd0, 12'd4095, 12'd4095, 1'b0,
			'{12'd0, 12'd0, 24'd0, 1'b0}}
	};

	center_crop_nearest_scaler_addr #(
		.MAX_DIM(MAX_DIM)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic longint unsigned clamp_dim(logic [CFG_W-1:0] v);
		if (v > MAX_DIM)
			return 64'(MAX_DIM);
		return 64'(v);
	endfunction

	// centred crop window with the target aspect ratio
	function automatic void update_window();
		longint unsigned sw, sh, tw, th, wide, tall, keep;
		sw = clamp_dim(reg_file[REG_SRC_W]);
		sh = clamp_dim(reg_file[REG_SRC_H]);
		tw = clamp_dim(reg_file[REG_TGT_W]);
		th = clamp_dim(reg_file[REG_TGT_H]);
		win_left = 0;
		win_top = 0;
		win_cols = sw;
		win_rows = sh;
		win_empty = (sw == 0) || (sh == 0) || (tw == 0) || (th == 0);
		if (!win_empty) begin
			wide = sw * th;
			tall = sh * tw;
			if (wide > tall) begin
				keep = tall / th;
				win_cols = keep;
				win_left = (sw - keep) / 2;
			end else if (wide < tall) begin
				keep = wide / tw;
				win_rows = keep;
				win_top = (sh - keep) / 2;
			end
		end
	endfunction

	function automatic src_pixel_t map_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
		longint unsigned tw, th, x, y, sx, sy, pitch;
		src_pixel_t res;
		res.in_col = '0;
		res.in_row = '0;
		res.in_address = '0;
		res.skip = 1'b1;
		if (!win_empty) begin
			tw = clamp_dim(reg_file[REG_TGT_W]);
			th = clamp_dim(reg_file[REG_TGT_H]);
			x = 64'(col);
			y = 64'(row);
			if (x > tw - 1)
				x = tw - 1;
			if (y > th - 1)
				y = th - 1;
			sx = win_left + x * win_cols / tw;
			sy = win_top + y * win_rows / th;
			pitch = clamp_dim(reg_file[REG_SRC_STRD]);
			res.in_col = COORD_W'(sx);
			res.in_row = COORD_W'(sy);
			res.in_address = ADDR_W'(sy * pitch + sx);
			res.skip = pitch < clamp_dim(reg_file[REG_SRC_W]);
		end
		return res;
	endfunction

	function automatic logic [CFG_W-1:0] pick_dim();
		int unsigned roll;
		roll = $urandom_range(19);
		case (roll)
			0: return '0;
			1: return CFG_W'(1);
			2: return CFG_W'(MAX_DIM);
			3: return CFG_W'($urandom_range(CFG_TOP, MAX_DIM + 1));
			4, 5, 6, 7, 8, 9: return CFG_W'($urandom_range(64, 1));
			default: return CFG_W'($urandom_range(MAX_DIM, 1));
		endcase
	endfunction

	function automatic void check_field(string name, logic [ADDR_W-1:0] want,
			logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < REG_COUNT) begin
			reg_file[idx] = value;
			update_window();
		end
		// window recompute holds the input side off
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
			input bit fixed, input src_pixel_t want);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {row, col};
		do @(posedge clk); while (!s_axis_tready);
		if (fixed)
			pending_q.push_back(want);
		else
			pending_q.push_back(map_pixel(col, row));
	endtask

	task automatic stream_pixels(input int unsigned count);
		logic [COORD_W-1:0] col, row;
		int unsigned col_top, row_top;
		src_pixel_t none;
		none = map_pixel('0, '0);
		col_top = (clamp_dim(reg_file[REG_TGT_W]) == 0) ? COORD_TOP :
			int'(clamp_dim(reg_file[REG_TGT_W])) - 1;
		row_top = (clamp_dim(reg_file[REG_TGT_H]) == 0) ? COORD_TOP :
			int'(clamp_dim(reg_file[REG_TGT_H])) - 1;
		repeat (count) begin
			if ($urandom_range(99) < 85) begin
				col = COORD_W'($urandom_range(col_top, 0));
				row = COORD_W'($urandom_range(row_top, 0));
			end else begin
				col = COORD_W'($urandom());
				row = COORD_W'($urandom());
			end
			send_pixel(col, row, 1'b0, none);
			if ($urandom_range(199) == 0)
				wait_drained();
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : result_sink
		src_pixel_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("result transfer with nothing pending: in_col %0d in_row %0d",
					m_axis_tdata[COORD_W-1:0], m_axis_tdata[2*COORD_W-1:COORD_W]);
				mismatches++;
			end else begin
				want = pending_q.pop_front();
				check_field("in_col", ADDR_W'(want.in_col),
					ADDR_W'(m_axis_tdata[COORD_W-1:0]));
				check_field("in_row", ADDR_W'(want.in_row),
					ADDR_W'(m_axis_tdata[2*COORD_W-1:COORD_W]));
				check_field("in_address", want.in_address, m_axis_tdata[2*COORD_W +: ADDR_W]);
				check_field("skip", ADDR_W'(want.skip), ADDR_W'(m_axis_tuser));
			end
		end
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : watchdog
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("[center_crop_nearest_scaler_addr] ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		reg_file[REG_SRC_W] = 13'd400;
		reg_file[REG_SRC_H] = 13'd400;
		reg_file[REG_SRC_STRD] = 13'd400;
		reg_file[REG_TGT_W] = 13'd240;
		reg_file[REG_TGT_H] = 13'd240;
		update_window();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == DO_WRITE)
				write_reg(dir_table[i].idx, dir_table[i].value);
			else
				send_pixel(dir_table[i].col, dir_table[i].row, dir_table[i].fixed,
					dir_table[i].want);
		end

		// register phases: all at the top, all at one, then random mixes
		for (int phase = 0; phase < PHASES; phase++) begin
			steady = (phase >= 10) && (phase < 14);
			for (int idx = 0; idx < REG_COUNT; idx++) begin
				if (phase == 0)
					write_reg(REG_IDX_W'(idx), CFG_W'(MAX_DIM));
				else if (phase == 1)
					write_reg(REG_IDX_W'(idx), CFG_W'(1));
				else if ($urandom_range(1) == 1)
					write_reg(REG_IDX_W'(idx), pick_dim());
			end
			if ($urandom_range(3) == 0)
				write_reg(REG_IDX_W'($urandom_range((1 << REG_IDX_W) - 1, REG_COUNT)),
					CFG_W'($urandom()));
			stream_pixels($urandom_range(95, 55));
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[center_crop_nearest_scaler_addr] OK");
		else
			$display("[center_crop_nearest_scaler_addr] ERROR");
		$finish;
	end

endmodule
